// ----- sv/irysf_pkg.sv -----
// Shared types, constants and arithmetic helpers for the IMU roll and yaw stability filter.
// Used by irysf_dp, irysf_ctrl and the top level; depends on nothing else.
package irysf_pkg;

    localparam int FRAC_BITS    = 12;
    localparam int ONE          = 1 << FRAC_BITS;
    localparam int CORDIC_STEPS = 16;
    localparam int STEP_W       = 5;
    localparam int ANG_BITS     = 30;
    localparam int ANG_SHIFT    = ANG_BITS - FRAC_BITS;
    localparam int GAIN_BITS    = 8;
    localparam int RATIO_MIN    = ONE / 1000;

    localparam logic signed [33:0] PI_Q30      = 34'sd3373259426;
    localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic [40:0]        EXPECT_MAX  = 41'h100_0000_0000;

    localparam logic [2:0] REG_ROLL_W     = 3'd0;
    localparam logic [2:0] REG_RATE_W     = 3'd1;
    localparam logic [2:0] REG_YAW_W      = 3'd2;
    localparam logic [2:0] REG_ATT_GAIN   = 3'd3;
    localparam logic [2:0] REG_ATT_CAP    = 3'd4;
    localparam logic [2:0] REG_AXLE       = 3'd5;
    localparam logic [2:0] REG_YAW_GAIN   = 3'd6;
    localparam logic [2:0] REG_ROLL_LIMIT = 3'd7;

    typedef struct packed {
        logic [12:0] roll_w;
        logic [12:0] rate_w;
        logic [12:0] yaw_w;
        logic [15:0] att_gain;
        logic [12:0] att_cap;
        logic [15:0] axle;
        logic [15:0] yaw_gain;
        logic [14:0] roll_limit;
    } cfg_t;

    typedef struct packed {
        logic              load;
        logic              prod;
        logic              setup;
        logic              iter;
        logic              roll;
        logic              rate;
        logic              scale;
        logic              div_start;
        logic              corr;
        logic              finish;
        logic [STEP_W-1:0] step;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic out_free;
    } status_t;

    // Arctangent of 2^-i in Q30 radians.
    function automatic logic [30:0] atan_q30(input logic [STEP_W-1:0] idx);
        logic [30:0] v;
        case (idx)
            5'd0:    v = 31'h3243F6A8;
            5'd1:    v = 31'h1DAC6705;
            5'd2:    v = 31'h0FADBAFC;
            5'd3:    v = 31'h07F56EA6;
            5'd4:    v = 31'h03FEAB76;
            5'd5:    v = 31'h01FFD55B;
            5'd6:    v = 31'h00FFFAAA;
            5'd7:    v = 31'h007FFF55;
            5'd8:    v = 31'h003FFFEA;
            5'd9:    v = 31'h001FFFFD;
            5'd10:   v = 31'h000FFFFF;
            5'd11:   v = 31'h0007FFFF;
            5'd12:   v = 31'h0003FFFF;
            5'd13:   v = 31'h0001FFFF;
            5'd14:   v = 31'h0000FFFF;
            5'd15:   v = 31'h00007FFF;
            5'd16:   v = 31'h00003FFF;
            5'd17:   v = 31'h00001FFF;
            5'd18:   v = 31'h00000FFF;
            5'd19:   v = 31'h000007FF;
            5'd20:   v = 31'h000003FF;
            5'd21:   v = 31'h000001FF;
            5'd22:   v = 31'h000000FF;
            5'd23:   v = 31'h0000007F;
            default: v = 31'h0;
        endcase
        return v;
    endfunction

    // Exponential low-pass update with rounding; weights above one saturate to one.
    function automatic logic signed [15:0] lowpass(input logic signed [15:0] est,
                                                   input logic signed [15:0] x,
                                                   input logic [12:0] w);
        logic [12:0]        wc;
        logic [12:0]        wr;
        logic signed [30:0] acc;
        wc  = (w > 13'(ONE)) ? 13'(ONE) : w;
        wr  = 13'(ONE) - wc;
        acc = 31'(signed'({1'b0, wc})) * 31'(x) + 31'(signed'({1'b0, wr})) * 31'(est)
              + 31'(ONE / 2);
        return acc[FRAC_BITS+15:FRAC_BITS];
    endfunction

endpackage

// ----- sv/irysf_div.sv -----
// Restoring divider producing one quotient bit per cycle, with an overflow flag.
// Depends on nothing; instantiated twice by irysf_dp.
module irysf_div #(
    parameter int DIVIDEND_W = 59,
    parameter int DIVISOR_W  = 47,
    parameter int QUOT_W     = 41
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  done,
    output logic                  overflow,
    output logic [QUOT_W-1:0]     quotient
);

    localparam int SH_W  = DIVISOR_W + QUOT_W - 1;
    localparam int CMP_W = (DIVIDEND_W > SH_W + 1) ? DIVIDEND_W : SH_W + 1;
    localparam int CNT_W = $clog2(QUOT_W + 1);

    logic                  busy_reg;
    logic                  done_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [DIVIDEND_W-1:0] rem_reg;
    logic [SH_W-1:0]       dsh_reg;
    logic [QUOT_W-1:0]     quot_reg;
    logic                  ovf_reg;

    logic             ge;
    logic [CMP_W-1:0] diff;

    assign ge   = CMP_W'(rem_reg) >= CMP_W'(dsh_reg);
    assign diff = CMP_W'(rem_reg) - CMP_W'(dsh_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(QUOT_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= dividend;
            dsh_reg  <= SH_W'(divisor) << (QUOT_W - 1);
            quot_reg <= '0;
            ovf_reg  <= CMP_W'(dividend) >= (CMP_W'(divisor) << QUOT_W);
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                rem_reg <= diff[DIVIDEND_W-1:0];
            end
            quot_reg <= {quot_reg[QUOT_W-2:0], ge};
            dsh_reg  <= dsh_reg >> 1;
        end
    end

    assign done     = done_reg;
    assign overflow = ovf_reg;
    assign quotient = quot_reg;

endmodule

// ----- sv/irysf_dp.sv -----
// Datapath: input capture, quaternion products, two CORDICs, three low-pass filters,
// attenuation, yaw correction, roll ratio and the output register. Uses irysf_pkg, irysf_div.
module irysf_dp (
    input  logic                     clk,
    input  logic                     rst_n,
    input  irysf_pkg::cfg_t          cfg,
    input  irysf_pkg::cmd_t          cmd,
    output irysf_pkg::status_t       status,
    input  logic signed [15:0]       quat_w,
    input  logic signed [15:0]       quat_x,
    input  logic signed [15:0]       quat_y,
    input  logic signed [15:0]       quat_z,
    input  logic signed [15:0]       measured_roll_rate,
    input  logic signed [15:0]       measured_yaw_rate,
    input  logic signed [15:0]       vehicle_speed,
    input  logic signed [13:0]       steer_angle,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [14:0]       smoothed_roll,
    output logic signed [15:0]       smoothed_roll_rate,
    output logic signed [15:0]       smoothed_yaw_rate,
    output logic [12:0]              steering_attenuation,
    output logic signed [15:0]       yaw_correction,
    output logic [12:0]              lean_ratio
);

    logic signed [15:0] qw_reg, qx_reg, qy_reg, qz_reg, rr_reg, yr_reg, spd_reg;
    logic signed [13:0] steer_reg;
    logic signed [31:0] p_wx_reg, p_yz_reg, p_xx_reg, p_yy_reg;
    logic signed [37:0] vx_reg, vy_reg;
    logic signed [33:0] vz_reg;
    logic               zero_reg;
    logic signed [32:0] rx_reg, ry_reg;
    logic signed [33:0] rz_reg;
    logic signed [15:0] roll_est_reg, rate_est_reg, yaw_est_reg;
    logic [12:0]        atten_reg;
    logic [46:0]        num_reg, den_reg;
    logic [15:0]        ar_reg;
    logic               exp_sat_reg, neg_reg, spd_ok_reg;
    logic signed [41:0] corr_prod_reg;
    logic [12:0]        ratio_reg;
    logic               out_valid_reg;
    logic signed [14:0] o_roll_reg;
    logic signed [15:0] o_rate_reg, o_yaw_reg, o_corr_reg;
    logic [12:0]        o_atten_reg, o_ratio_reg;

    // Set-up stage terms.
    logic signed [33:0] sn;
    logic signed [34:0] cs;
    logic signed [33:0] z0, z_red;
    // CORDIC step terms.
    logic signed [33:0] step_ang;
    logic signed [37:0] vdx, vdy;
    logic signed [32:0] rdx, rdy;
    // Roll rounding.
    logic signed [33:0] ang;
    logic signed [34:0] rsum, rsh;
    logic signed [15:0] roll_val;
    // Attenuation and scaling.
    logic [15:0]        absr, spd_abs;
    logic [31:0]        att_p;
    logic [23:0]        att_s;
    logic [32:0]        cy_abs;
    // Correction.
    logic               y_done, y_ovf, r_done, r_ovf;
    logic [40:0]        y_q, mag;
    logic [12:0]        r_q;
    logic signed [41:0] expect_v;
    logic signed [42:0] err;
    logic signed [25:0] err_c;
    logic signed [42:0] csum, cr;

    always_comb
    begin
        sn = (34'(p_wx_reg) + 34'(p_yz_reg)) <<< 1;
        cs = 35'sd268435456 - ((35'(p_xx_reg) + 35'(p_yy_reg)) <<< 1);
        z0 = 34'(steer_reg) <<< irysf_pkg::ANG_SHIFT;
        if (z0 > irysf_pkg::HALF_PI_Q30)
        begin
            z_red = z0 - irysf_pkg::PI_Q30;
        end
        else if (z0 < -irysf_pkg::HALF_PI_Q30)
        begin
            z_red = z0 + irysf_pkg::PI_Q30;
        end
        else
        begin
            z_red = z0;
        end

        step_ang = signed'({3'b000, irysf_pkg::atan_q30(cmd.step)});
        vdx = vy_reg >>> cmd.step;
        vdy = vx_reg >>> cmd.step;
        rdx = ry_reg >>> cmd.step;
        rdy = rx_reg >>> cmd.step;

        ang  = zero_reg ? 34'sd0 : vz_reg;
        rsum = 35'(ang) + 35'sd131072;
        rsh  = rsum >>> irysf_pkg::ANG_SHIFT;
        if (rsh > 35'sd16383)
        begin
            roll_val = 16'sd16383;
        end
        else if (rsh < -35'sd16384)
        begin
            roll_val = -16'sd16384;
        end
        else
        begin
            roll_val = rsh[15:0];
        end

        absr    = rate_est_reg[15] ? 16'(-rate_est_reg) : 16'(rate_est_reg);
        att_p   = 32'(cfg.att_gain) * 32'(absr);
        att_s   = att_p[31:irysf_pkg::GAIN_BITS];
        spd_abs = spd_reg[15] ? 16'(-spd_reg) : 16'(spd_reg);
        cy_abs  = ry_reg[32] ? 33'(-ry_reg) : 33'(ry_reg);

        mag = (exp_sat_reg || y_ovf || y_q > irysf_pkg::EXPECT_MAX) ?
              irysf_pkg::EXPECT_MAX : y_q;
        expect_v = neg_reg ? -signed'({1'b0, mag}) : signed'({1'b0, mag});
        err = 43'(expect_v) - 43'(yaw_est_reg);
        // Beyond this bound any nonzero gain saturates the correction anyway.
        if (err > 43'sd16777216)
        begin
            err_c = 26'sd16777216;
        end
        else if (err < -43'sd16777216)
        begin
            err_c = -26'sd16777216;
        end
        else
        begin
            err_c = err[25:0];
        end

        csum = 43'(corr_prod_reg) + 43'sd128;
        cr   = csum >>> irysf_pkg::GAIN_BITS;
    end

    irysf_div #(.DIVIDEND_W(59), .DIVISOR_W(47), .QUOT_W(41)) u_yaw_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend ({num_reg, 12'b0}),
        .divisor  (den_reg),
        .done     (y_done),
        .overflow (y_ovf),
        .quotient (y_q)
    );

    irysf_div #(.DIVIDEND_W(28), .DIVISOR_W(15), .QUOT_W(13)) u_ratio_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend ({ar_reg, 12'b0}),
        .divisor  (cfg.roll_limit),
        .done     (r_done),
        .overflow (r_ovf),
        .quotient (r_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            roll_est_reg  <= '0;
            rate_est_reg  <= '0;
            yaw_est_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.setup)
            begin
                rate_est_reg <= irysf_pkg::lowpass(rate_est_reg, rr_reg, cfg.rate_w);
            end
            if (cmd.roll)
            begin
                roll_est_reg <= irysf_pkg::lowpass(roll_est_reg, roll_val, cfg.roll_w);
            end
            if (cmd.rate)
            begin
                yaw_est_reg <= irysf_pkg::lowpass(yaw_est_reg, yr_reg, cfg.yaw_w);
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            qw_reg    <= quat_w;
            qx_reg    <= quat_x;
            qy_reg    <= quat_y;
            qz_reg    <= quat_z;
            rr_reg    <= measured_roll_rate;
            yr_reg    <= measured_yaw_rate;
            spd_reg   <= vehicle_speed;
            steer_reg <= steer_angle;
        end
        if (cmd.prod)
        begin
            p_wx_reg <= 32'(qw_reg) * 32'(qx_reg);
            p_yz_reg <= 32'(qy_reg) * 32'(qz_reg);
            p_xx_reg <= 32'(qx_reg) * 32'(qx_reg);
            p_yy_reg <= 32'(qy_reg) * 32'(qy_reg);
        end
        if (cmd.setup)
        begin
            zero_reg <= (sn == 34'sd0) && (cs == 35'sd0);
            // A negative x half-plane is folded over by a half turn first.
            if (cs < 35'sd0)
            begin
                vx_reg <= -38'(cs);
                vy_reg <= -38'(sn);
                vz_reg <= (sn >= 34'sd0) ? irysf_pkg::PI_Q30 : -irysf_pkg::PI_Q30;
            end
            else
            begin
                vx_reg <= 38'(cs);
                vy_reg <= 38'(sn);
                vz_reg <= '0;
            end
            rx_reg <= 33'sd1073741824;
            ry_reg <= '0;
            rz_reg <= z_red;
        end
        if (cmd.iter)
        begin
            if (vy_reg > 38'sd0)
            begin
                vx_reg <= vx_reg + vdx;
                vy_reg <= vy_reg - vdy;
                vz_reg <= vz_reg + step_ang;
            end
            else
            begin
                vx_reg <= vx_reg - vdx;
                vy_reg <= vy_reg + vdy;
                vz_reg <= vz_reg - step_ang;
            end
            if (rz_reg >= 34'sd0)
            begin
                rx_reg <= rx_reg - rdx;
                ry_reg <= ry_reg + rdy;
                rz_reg <= rz_reg - step_ang;
            end
            else
            begin
                rx_reg <= rx_reg + rdx;
                ry_reg <= ry_reg - rdy;
                rz_reg <= rz_reg + step_ang;
            end
        end
        if (cmd.rate)
        begin
            atten_reg <= (att_s > 24'(cfg.att_cap)) ? cfg.att_cap : att_s[12:0];
        end
        if (cmd.scale)
        begin
            num_reg     <= 47'(spd_abs) * 47'(cy_abs[30:0]);
            den_reg     <= 47'(rx_reg[30:0]) * 47'(cfg.axle);
            exp_sat_reg <= (rx_reg <= 33'sd0) || (cfg.axle == 16'd0);
            neg_reg     <= spd_reg[15] ^ ry_reg[32];
            spd_ok_reg  <= spd_abs >= 16'(1 << (irysf_pkg::GAIN_BITS - 1));
            ar_reg      <= roll_est_reg[15] ? 16'(-roll_est_reg) : 16'(roll_est_reg);
        end
        if (cmd.corr)
        begin
            corr_prod_reg <= 42'(signed'(cfg.yaw_gain)) * 42'(err_c);
            if (cfg.roll_limit <= 15'(irysf_pkg::RATIO_MIN))
            begin
                ratio_reg <= '0;
            end
            else if (r_ovf || r_q > 13'(irysf_pkg::ONE))
            begin
                ratio_reg <= 13'(irysf_pkg::ONE);
            end
            else
            begin
                ratio_reg <= r_q;
            end
        end
        if (cmd.finish)
        begin
            o_roll_reg  <= roll_est_reg[14:0];
            o_rate_reg  <= rate_est_reg;
            o_yaw_reg   <= yaw_est_reg;
            o_atten_reg <= atten_reg;
            o_ratio_reg <= ratio_reg;
            if (!spd_ok_reg)
            begin
                o_corr_reg <= '0;
            end
            else if (cr > 43'sd32767)
            begin
                o_corr_reg <= 16'sd32767;
            end
            else if (cr < -43'sd32768)
            begin
                o_corr_reg <= -16'sd32768;
            end
            else
            begin
                o_corr_reg <= cr[15:0];
            end
        end
    end

    assign status.div_done = y_done && r_done;
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid            = out_valid_reg;
    assign smoothed_roll        = o_roll_reg;
    assign smoothed_roll_rate   = o_rate_reg;
    assign smoothed_yaw_rate    = o_yaw_reg;
    assign steering_attenuation = o_atten_reg;
    assign yaw_correction       = o_corr_reg;
    assign lean_ratio           = o_ratio_reg;

endmodule

// ----- sv/irysf_ctrl.sv -----
// Controller state machine sequencing one sample through the datapath.
// Uses irysf_pkg for the command and status structs and the CORDIC step count.
module irysf_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  irysf_pkg::status_t status,
    output irysf_pkg::cmd_t    cmd
);

    typedef enum logic [10:0] {
        ST_IDLE   = 11'b000_0000_0001,
        ST_PROD   = 11'b000_0000_0010,
        ST_SETUP  = 11'b000_0000_0100,
        ST_ITER   = 11'b000_0000_1000,
        ST_ROLL   = 11'b000_0001_0000,
        ST_RATE   = 11'b000_0010_0000,
        ST_SCALE  = 11'b000_0100_0000,
        ST_DSTART = 11'b000_1000_0000,
        ST_DIVIDE = 11'b001_0000_0000,
        ST_CORR   = 11'b010_0000_0000,
        ST_DONE   = 11'b100_0000_0000
    } state_t;

    state_t                       state_reg, state_next;
    logic [irysf_pkg::STEP_W-1:0] step_reg, step_next;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        cmd.step   = step_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.load = in_valid;
                if (in_valid)
                begin
                    state_next = ST_PROD;
                end
            end
            ST_PROD:
            begin
                cmd.prod   = 1'b1;
                state_next = ST_SETUP;
            end
            ST_SETUP:
            begin
                cmd.setup  = 1'b1;
                step_next  = '0;
                state_next = ST_ITER;
            end
            ST_ITER:
            begin
                cmd.iter  = 1'b1;
                step_next = step_reg + 1'b1;
                if (step_reg == irysf_pkg::STEP_W'(irysf_pkg::CORDIC_STEPS - 1))
                begin
                    state_next = ST_ROLL;
                end
            end
            ST_ROLL:
            begin
                cmd.roll   = 1'b1;
                state_next = ST_RATE;
            end
            ST_RATE:
            begin
                cmd.rate   = 1'b1;
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = ST_DSTART;
            end
            ST_DSTART:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                if (status.div_done)
                begin
                    state_next = ST_CORR;
                end
            end
            ST_CORR:
            begin
                cmd.corr   = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // Wait here until the previous result transaction has left the output register.
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

endmodule

// ----- sv/imu_roll_yaw_stability_filter.sv -----
// IMU roll and yaw stability filter, top level: configuration registers, controller, datapath.
// A sample is accepted only in idle; its result is presented after the 16 CORDIC steps,
// the 41-step restoring yaw division and any wait for the output register; one sample at a time.
// The output register lets a new sample in while the previous result transaction still waits.
// Reset (rst_n, asynchronous, active low) loads the register defaults and zeroes the filters.
// Uses irysf_pkg, irysf_ctrl and irysf_dp.
module imu_roll_yaw_stability_filter (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] quat_w,
    input  logic signed [15:0] quat_x,
    input  logic signed [15:0] quat_y,
    input  logic signed [15:0] quat_z,
    input  logic signed [15:0] measured_roll_rate,
    input  logic signed [15:0] measured_yaw_rate,
    input  logic signed [15:0] vehicle_speed,
    input  logic signed [13:0] steer_angle,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [14:0] smoothed_roll,
    output logic signed [15:0] smoothed_roll_rate,
    output logic signed [15:0] smoothed_yaw_rate,
    output logic [12:0]        steering_attenuation,
    output logic signed [15:0] yaw_correction,
    output logic [12:0]        lean_ratio,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    irysf_pkg::cfg_t    cfg_reg;
    irysf_pkg::cmd_t    cmd;
    irysf_pkg::status_t status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.roll_w     <= 13'd1024;
            cfg_reg.rate_w     <= 13'd1024;
            cfg_reg.yaw_w      <= 13'd1024;
            cfg_reg.att_gain   <= 16'd256;
            cfg_reg.att_cap    <= 13'd4096;
            cfg_reg.axle       <= 16'd84;
            cfg_reg.yaw_gain   <= 16'd256;
            cfg_reg.roll_limit <= 15'd2048;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                irysf_pkg::REG_ROLL_W:     cfg_reg.roll_w     <= cfg_data[12:0];
                irysf_pkg::REG_RATE_W:     cfg_reg.rate_w     <= cfg_data[12:0];
                irysf_pkg::REG_YAW_W:      cfg_reg.yaw_w      <= cfg_data[12:0];
                irysf_pkg::REG_ATT_GAIN:   cfg_reg.att_gain   <= cfg_data;
                irysf_pkg::REG_ATT_CAP:    cfg_reg.att_cap    <= cfg_data[12:0];
                irysf_pkg::REG_AXLE:       cfg_reg.axle       <= cfg_data;
                irysf_pkg::REG_YAW_GAIN:   cfg_reg.yaw_gain   <= cfg_data;
                irysf_pkg::REG_ROLL_LIMIT: cfg_reg.roll_limit <= cfg_data[14:0];
                default:                   cfg_reg.roll_w     <= cfg_reg.roll_w;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    irysf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    irysf_dp u_dp (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cfg                  (cfg_reg),
        .cmd                  (cmd),
        .status               (status),
        .quat_w               (quat_w),
        .quat_x               (quat_x),
        .quat_y               (quat_y),
        .quat_z               (quat_z),
        .measured_roll_rate   (measured_roll_rate),
        .measured_yaw_rate    (measured_yaw_rate),
        .vehicle_speed        (vehicle_speed),
        .steer_angle          (steer_angle),
        .out_valid            (out_valid),
        .out_ready            (out_ready),
        .smoothed_roll        (smoothed_roll),
        .smoothed_roll_rate   (smoothed_roll_rate),
        .smoothed_yaw_rate    (smoothed_yaw_rate),
        .steering_attenuation (steering_attenuation),
        .yaw_correction       (yaw_correction),
        .lean_ratio           (lean_ratio)
    );

endmodule
